### rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  typedef enum logic [2:0] {
    OP_BUF_WRITE = 3'd0,
    OP_BUF_READ  = 3'd1,
    OP_START     = 3'd2,
    OP_STATUS    = 3'd3,
    OP_TICK      = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_START    = 3'd1,
    ACT_TX       = 3'd2,
    ACT_RX_ACK   = 3'd3,
    ACT_RX_NACK  = 3'd4,
    ACT_STOP     = 3'd5,
    ACT_END_HOLD = 3'd6
  } act_e;

  // masked bus engine status codes
  localparam logic [7:0] ST_MASK     = 8'hF8;
  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_RSTART   = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK = 8'h18;
  localparam logic [7:0] ST_DTX_ACK  = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK = 8'h40;
  localparam logic [7:0] ST_DRX_ACK  = 8'h50;
  localparam logic [7:0] ST_DRX_NACK = 8'h58;
  localparam logic [7:0] ST_IDLE_WR  = 8'hF8;
  localparam logic [7:0] ST_IDLE_RD  = 8'h00;

  localparam logic [15:0] TIMEOUT_RESET = 16'd300;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [2:0] operation;
    logic [4:0] buf_index;
    logic [7:0] data_byte;
    logic [6:0] target_address;
    logic       direction;
    logic [5:0] length;
    logic       keep_line;
    logic [7:0] bus_status;
    logic [7:0] received_byte;
  } item_t;

  typedef struct packed {
    act_e       action;
    logic [7:0] tx_byte;
    logic       busy;
    logic       done;
    logic       success;
    logic       timed_out;
    logic [7:0] last_status;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

endpackage

### rtl/i2cms_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_buf
// Message buffer: one write port, two registered read ports with
// write-to-read forwarding.
// ----------------------------------------------------------------------------
module i2cms_buf #(
  parameter int Depth = 32,
  parameter int Aw    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr0_i,
  input  logic [Aw-1:0] raddr1_i,
  output logic [7:0]    rdata0_o,
  output logic [7:0]    rdata1_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata0_q;
  logic [7:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // a write in the same cycle wins over the stored byte
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= (we_i && waddr_i == raddr0_i) ? wdata_i : mem[raddr0_i];
      rdata1_q <= (we_i && waddr_i == raddr1_i) ? wdata_i : mem[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

### rtl/i2cms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Transfer state and next-action decision for one registered item.
// ----------------------------------------------------------------------------
module i2cms_ctrl #(
  parameter int Depth = 32,
  parameter int Aw    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  i2cms_pkg::item_t    item_i,
  input  logic [7:0]          rd_buf_i,
  input  logic [7:0]          tx_buf_i,
  input  logic [15:0]         timeout_limit_i,
  output logic                we_o,
  output logic [Aw-1:0]       waddr_o,
  output logic [7:0]          wdata_o,
  output logic [Aw-1:0]       cnt_addr_o,
  output i2cms_pkg::res_t     res_o
);
  import i2cms_pkg::*;

  logic [5:0]  cnt_q, cnt_d, cnt_n;
  logic [5:0]  len_q, len_d;
  logic [6:0]  addr_q, addr_d;
  logic        rmode_q, rmode_d;
  logic        hold_q, hold_d;
  logic        busy_q, busy_d;
  logic [7:0]  stat_q, stat_d;
  logic [15:0] ticks_q, ticks_d;

  logic        finish;
  logic        cnt_ok;
  logic        idx_ok;
  logic [7:0]  st;
  logic [5:0]  len_sat;
  logic        store;
  op_e         op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      len_q   <= '0;
      addr_q  <= '0;
      rmode_q <= 1'b0;
      hold_q  <= 1'b0;
      busy_q  <= 1'b0;
      stat_q  <= '0;
      ticks_q <= '0;
    end else if (fire_i) begin
      cnt_q   <= cnt_n;
      len_q   <= len_d;
      addr_q  <= addr_d;
      rmode_q <= rmode_d;
      hold_q  <= hold_d;
      busy_q  <= busy_d;
      stat_q  <= stat_d;
      ticks_q <= ticks_d;
    end
  end

  assign cnt_d      = fire_i ? cnt_n : cnt_q;
  assign cnt_addr_o = Aw'(cnt_d);

  always_comb begin
    op      = op_e'(item_i.operation);
    st      = item_i.bus_status & ST_MASK;
    cnt_ok  = (cnt_q < len_q) && (int'(cnt_q) < Depth);
    idx_ok  = int'(item_i.buf_index) < Depth;
    len_sat = (int'(item_i.length) > Depth) ? 6'(Depth) : item_i.length;
    finish  = 1'b0;
    store   = 1'b0;

    cnt_n   = cnt_q;
    len_d   = len_q;
    addr_d  = addr_q;
    rmode_d = rmode_q;
    hold_d  = hold_q;
    busy_d  = busy_q;
    stat_d  = stat_q;
    ticks_d = ticks_q;

    we_o    = 1'b0;
    waddr_o = Aw'(item_i.buf_index);
    wdata_o = item_i.data_byte;

    res_o = '{action: ACT_NONE, tx_byte: 8'h00, busy: 1'b0, done: 1'b0,
              success: 1'b0, timed_out: 1'b0, last_status: 8'h00,
              read_data: 8'h00, rejected: 1'b0};

    unique case (op)
      OP_BUF_WRITE: begin
        we_o = fire_i && idx_ok;
      end
      OP_BUF_READ: begin
        res_o.read_data = idx_ok ? rd_buf_i : 8'h00;
      end
      OP_START: begin
        if (busy_q) begin
          res_o.rejected = 1'b1;
        end else begin
          addr_d       = item_i.target_address;
          rmode_d      = item_i.direction;
          len_d        = len_sat;
          hold_d       = item_i.keep_line;
          cnt_n        = '0;
          ticks_d      = '0;
          stat_d       = item_i.direction ? ST_IDLE_RD : ST_IDLE_WR;
          busy_d       = 1'b1;
          res_o.action = ACT_START;
        end
      end
      OP_STATUS: begin
        if (busy_q) begin
          stat_d = st;
          unique case (st)
            ST_START, ST_RSTART: begin
              res_o.action  = ACT_TX;
              res_o.tx_byte = {addr_q, rmode_q};
            end
            ST_SLAW_ACK, ST_DTX_ACK: begin
              if (cnt_ok) begin
                res_o.action  = ACT_TX;
                res_o.tx_byte = tx_buf_i;
                cnt_n         = cnt_q + 6'd1;
              end else begin
                finish = 1'b1;
              end
            end
            ST_DRX_ACK, ST_SLAR_ACK: begin
              store = (st == ST_DRX_ACK) && cnt_ok;
              if (store) begin
                cnt_n = cnt_q + 6'd1;
              end
              if (len_q == '0) begin
                finish = 1'b1;
              end else begin
                // counter after the store decides ack or nack
                res_o.action = ((7'(cnt_n) + 7'd1) < 7'(len_q)) ? ACT_RX_ACK : ACT_RX_NACK;
              end
            end
            ST_DRX_NACK: begin
              store  = cnt_ok;
              if (store) begin
                cnt_n = cnt_q + 6'd1;
              end
              finish = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
          if (store) begin
            we_o    = fire_i;
            waddr_o = Aw'(cnt_q);
            wdata_o = item_i.received_byte;
          end
          if (finish) begin
            res_o.action = hold_q ? ACT_END_HOLD : ACT_STOP;
            busy_d       = 1'b0;
            res_o.done   = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (busy_q) begin
          if (ticks_q < TICKS_MAX) begin
            ticks_d = ticks_q + 16'd1;
          end
          if (ticks_d > timeout_limit_i) begin
            busy_d          = 1'b0;
            res_o.done      = 1'b1;
            res_o.timed_out = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // expected completion code depends on direction and zero length
    if (res_o.done) begin
      if (rmode_q) begin
        res_o.success = (len_q != '0) ? (stat_d == ST_DRX_NACK) : (stat_d == ST_SLAR_ACK);
      end else begin
        res_o.success = (len_q != '0) ? (stat_d == ST_DTX_ACK) : (stat_d == ST_SLAW_ACK);
      end
    end
    res_o.busy        = busy_d;
    res_o.last_status = stat_d;
  end

endmodule

### rtl/i2c_master_transaction_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Sequences one I2C master transfer over a byte-level bus engine.
//
//   channel  signals                      direction  transaction when
//   in       in_valid_i / in_stall_o      in         valid & !stall
//   out      out_valid_o / out_stall_i    out        valid & !stall
//   cfg      cfg_valid_i / cfg_ready_o    in         valid & ready
//
// One item per cycle while the output is not stalled; an accepted item passes
// through the input register and then the result register.
// Buffer reads are registered together with the input register.
// Reset clears all transfer state; buffer contents are unknown until written.
// A stalled output holds the input register, which then stalls the input.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [4:0]  buf_index_i,
  input  logic [7:0]  data_byte_i,
  input  logic [6:0]  target_address_i,
  input  logic        direction_i,
  input  logic [5:0]  length_i,
  input  logic        keep_line_i,
  input  logic [7:0]  bus_status_i,
  input  logic [7:0]  received_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [7:0]  tx_byte_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        success_o,
  output logic        timed_out_o,
  output logic [7:0]  last_status_o,
  output logic [7:0]  read_data_o,
  output logic        rejected_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import i2cms_pkg::*;

  localparam int Aw = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic        a_valid_q, a_valid_d;
  item_t       a_item_q;
  logic        out_valid_q, out_valid_d;
  res_t        out_res_q;
  logic [15:0] limit_q;

  logic        accept;
  logic        a_fire;
  res_t        res;
  logic        we;
  logic [Aw-1:0] waddr;
  logic [7:0]  wdata;
  logic [Aw-1:0] cnt_addr;
  logic [7:0]  rd_buf;
  logic [7:0]  tx_buf;

  assign a_fire     = a_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !a_fire;
  assign accept     = in_valid_i && !in_stall_o;
  assign a_valid_d  = accept ? 1'b1 : (a_fire ? 1'b0 : a_valid_q);
  assign out_valid_d = a_fire ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= TIMEOUT_RESET;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_item_q <= '{operation: operation_i, buf_index: buf_index_i,
                    data_byte: data_byte_i, target_address: target_address_i,
                    direction: direction_i, length: length_i,
                    keep_line: keep_line_i, bus_status: bus_status_i,
                    received_byte: received_byte_i};
    end
    if (a_fire) begin
      out_res_q <= res;
    end
  end

  i2cms_buf #(
    .Depth (BUFFER_DEPTH),
    .Aw    (Aw)
  ) u_buf (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .re_i     (accept),
    .raddr0_i (Aw'(buf_index_i)),
    .raddr1_i (cnt_addr),
    .rdata0_o (rd_buf),
    .rdata1_o (tx_buf)
  );

  i2cms_ctrl #(
    .Depth (BUFFER_DEPTH),
    .Aw    (Aw)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (a_fire),
    .item_i          (a_item_q),
    .rd_buf_i        (rd_buf),
    .tx_buf_i        (tx_buf),
    .timeout_limit_i (limit_q),
    .we_o            (we),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .cnt_addr_o      (cnt_addr),
    .res_o           (res)
  );

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_res_q.action;
  assign tx_byte_o     = out_res_q.tx_byte;
  assign busy_res_o    = out_res_q.busy;
  assign done_res_o    = out_res_q.done;
  assign success_o     = out_res_q.success;
  assign timed_out_o   = out_res_q.timed_out;
  assign last_status_o = out_res_q.last_status;
  assign read_data_o   = out_res_q.read_data;
  assign rejected_o    = out_res_q.rejected;

endmodule
